### hw/rtl/ip4rx_pkg.sv
`default_nettype none

package ip4rx_pkg;

  // Header geometry and field constants
  localparam int unsigned HdrWords = 10;
  localparam int unsigned CountW   = 4;
  localparam int unsigned SumW     = 20;

  localparam logic [CountW-1:0] HDR_WORDS   = CountW'(HdrWords);
  localparam logic [15:0]       HDR_BYTES   = 16'd20;
  localparam logic [7:0]        VER_IHL_20B = 8'h45;
  localparam int unsigned       MF_BIT_POS  = 13;
  localparam logic [15:0]       SUM_GOOD    = 16'hFFFF;

  // Header word positions
  localparam logic [CountW-1:0] W_VER_TOS  = CountW'(0);
  localparam logic [CountW-1:0] W_LENGTH   = CountW'(1);
  localparam logic [CountW-1:0] W_FLAGS    = CountW'(3);
  localparam logic [CountW-1:0] W_TTL_PROT = CountW'(4);
  localparam logic [CountW-1:0] W_DST_HI   = CountW'(8);
  localparam logic [CountW-1:0] W_DST_LO   = CountW'(9);

  // Protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [3:0] {
    V_BAD_LENGTH   = 4'd0,
    V_BAD_VERSION  = 4'd1,
    V_BAD_CHECKSUM = 4'd2,
    V_FRAGMENT     = 4'd3,
    V_NOT_LOCAL    = 4'd4,
    V_ICMP         = 4'd5,
    V_IGMP         = 4'd6,
    V_UDP          = 4'd7,
    V_TCP          = 4'd8,
    V_OTHER        = 4'd9
  } verdict_e;

  // Checks captured with the last header word, ahead of the verdict stage
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            len_bad;
    logic            ver_bad;
    logic            mf;
    logic            dst_local;
    logic [7:0]      protocol;
    logic [15:0]     total_length;
  } chk_t;

  function automatic verdict_e class_of(logic [7:0] proto);
    verdict_e v;
    unique case (proto)
      PROTO_ICMP: v = V_ICMP;
      PROTO_IGMP: v = V_IGMP;
      PROTO_UDP:  v = V_UDP;
      PROTO_TCP:  v = V_TCP;
      default:    v = V_OTHER;
    endcase
    return v;
  endfunction

  // Fold a 20-bit one's-complement sum twice into 16 bits
  function automatic logic [15:0] fold_sum(logic [SumW-1:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = 17'(s[SumW-1:16]) + 17'(s[15:0]);
    f2 = 17'(f1[16]) + 17'(f1[15:0]);
    return f2[15:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ip4rx_if.sv
`default_nettype none

// Header word request channel
interface ip4rx_hdr_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic        packet_start;
  logic [15:0] received_length;

  modport source (output valid, header_word, packet_start, received_length, input ready);
  modport sink   (input valid, header_word, packet_start, received_length, output ready);
endinterface

// Verdict request channel
interface ip4rx_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic        activity;
  logic [15:0] total_length;
  logic [7:0]  protocol;

  modport source (output valid, verdict, activity, total_length, protocol, input ready);
  modport sink   (input valid, verdict, activity, total_length, protocol, output ready);
endinterface

// Local address write channel
interface ip4rx_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ipv4_receive_header_check_top.sv
// Channel  Dir  Payload                                          Accept
// hdr_i    in   header_word, packet_start, received_length       valid & ready
// res_o    out  verdict, activity, total_length, protocol        valid & ready
// cfg_i    in   data (local_address)                              valid & ready
//
// One header word is taken per cycle while hdr_i.ready is high; words are summed
// and captured as they arrive. The last (tenth) word loads a check register; the
// verdict is then registered in the result register once that is free or taken.
// Reset clears the word count, sum, captured fields and the local address.
// A stalled result holds in the output register; words keep flowing until the
// check register is also full, then hdr_i.ready drops.
`default_nettype none

module ipv4_receive_header_check_top import ip4rx_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ip4rx_hdr_if.sink   hdr_i,
  ip4rx_res_if.source res_o,
  ip4rx_cfg_if.sink   cfg_i
);

  logic [31:0]       local_addr_q;
  logic [CountW-1:0] count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [15:0]       cap_len_q, cap_len_d;
  logic [15:0]       cap_rx_q, cap_rx_d;
  logic [7:0]        ver_q, ver_d;
  logic              mf_q, mf_d;
  logic [7:0]        proto_q, proto_d;
  logic [15:0]       dst_hi_q, dst_hi_d;

  logic              s1_valid_q;
  chk_t              s1_q, s1_d;
  logic              out_valid_q;
  verdict_e          out_verdict_q, out_verdict_d;
  logic              out_act_q, out_act_d;
  logic [15:0]       out_len_q;
  logic [7:0]        out_proto_q;

  logic              in_fire;
  logic              s1_adv;
  logic              last_word;
  logic [CountW-1:0] cnt_eff;
  logic [SumW-1:0]   sum_base;
  logic              word_live;

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign hdr_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = hdr_i.valid && hdr_i.ready;

  // Hold local address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      local_addr_q <= cfg_i.data;
    end
  end

  // Sum words and capture fields
  always_comb begin
    cnt_eff   = hdr_i.packet_start ? '0 : count_q;
    word_live = (cnt_eff < HDR_WORDS);
    sum_base  = (cnt_eff == '0) ? '0 : sum_q;
    count_d   = count_q;
    sum_d     = sum_q;
    cap_len_d = cap_len_q;
    cap_rx_d  = cap_rx_q;
    ver_d     = ver_q;
    mf_d      = mf_q;
    proto_d   = proto_q;
    dst_hi_d  = dst_hi_q;
    last_word = 1'b0;
    if (hdr_i.packet_start) begin
      count_d = '0;
      sum_d   = '0;
    end
    if (word_live) begin
      sum_d   = sum_base + SumW'(hdr_i.header_word);
      count_d = cnt_eff + CountW'(1);
      case (cnt_eff)
        W_VER_TOS: begin
          ver_d    = hdr_i.header_word[15:8];
          cap_rx_d = hdr_i.received_length;
        end
        W_LENGTH:   cap_len_d = hdr_i.header_word;
        W_FLAGS:    mf_d      = hdr_i.header_word[MF_BIT_POS];
        W_TTL_PROT: proto_d   = hdr_i.header_word[7:0];
        W_DST_HI:   dst_hi_d  = hdr_i.header_word;
        W_DST_LO:   last_word = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      cap_len_q <= '0;
      cap_rx_q  <= '0;
      ver_q     <= '0;
      mf_q      <= 1'b0;
      proto_q   <= '0;
      dst_hi_q  <= '0;
    end else if (in_fire) begin
      count_q   <= count_d;
      sum_q     <= sum_d;
      cap_len_q <= cap_len_d;
      cap_rx_q  <= cap_rx_d;
      ver_q     <= ver_d;
      mf_q      <= mf_d;
      proto_q   <= proto_d;
      dst_hi_q  <= dst_hi_d;
    end
  end

  // Form the checks on the last word
  always_comb begin
    s1_d.sum          = sum_d;
    s1_d.len_bad      = (cap_len_q <= HDR_BYTES) || (cap_len_q > cap_rx_q);
    s1_d.ver_bad      = (ver_q != VER_IHL_20B);
    s1_d.mf           = mf_q;
    s1_d.dst_local    = ({dst_hi_q, hdr_i.header_word} == local_addr_q);
    s1_d.protocol     = proto_q;
    s1_d.total_length = cap_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= last_word;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_word) begin
      s1_q <= s1_d;
    end
  end

  // Pick the verdict in check order
  always_comb begin
    out_act_d = 1'b0;
    if (s1_q.len_bad) begin
      out_verdict_d = V_BAD_LENGTH;
    end else if (s1_q.ver_bad) begin
      out_verdict_d = V_BAD_VERSION;
    end else if (fold_sum(s1_q.sum) != SUM_GOOD) begin
      out_verdict_d = V_BAD_CHECKSUM;
    end else if (s1_q.mf) begin
      out_verdict_d = V_FRAGMENT;
    end else begin
      out_act_d     = 1'b1;
      out_verdict_d = s1_q.dst_local ? class_of(s1_q.protocol) : V_NOT_LOCAL;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_verdict_q <= out_verdict_d;
      out_act_q     <= out_act_d;
      out_len_q     <= s1_q.total_length;
      out_proto_q   <= s1_q.protocol;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.verdict      = out_verdict_q;
  assign res_o.activity     = out_act_q;
  assign res_o.total_length = out_len_q;
  assign res_o.protocol     = out_proto_q;

  // Word count never runs past the header
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= HDR_WORDS)
    else $error("word count past header length");

  // A check entry only comes from an accepted last word
  a_s1_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(in_fire))
    else $error("check stage loaded without a word");

  // A new result always comes from the check stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a checked header");

  // Activity only with a verdict past the fragment check
  a_act_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q) |-> (out_verdict_q >= V_NOT_LOCAL))
    else $error("activity with an error verdict");

endmodule

`default_nettype wire
